### rtl/radial_vignette_correction_assert.svh
// assertion macros for the vignette correction checker
// expects clk_i and rst_ni in the scope of use
`ifndef RADIAL_VIGNETTE_CORRECTION_ASSERT_SVH
`define RADIAL_VIGNETTE_CORRECTION_ASSERT_SVH

// plain property, disabled while in reset
`define RVC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// overlapping implication
`define RVC_ASSERT_IMP(lbl, ante, cons, msg) \
  `RVC_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

### rtl/rvc_pkg.sv
// shared types and constants for the radial vignette correction pipeline
// no dependencies
package rvc_pkg;

  localparam int unsigned CENTER_BITS = 13;
  localparam int unsigned SHIFT_BITS  = 5;
  localparam int unsigned COEF_BITS   = 32;
  localparam int unsigned U_BITS      = 16;
  localparam int unsigned GAIN_BITS   = 24;
  localparam int unsigned POLY_SHIFT  = 24;
  localparam int unsigned OUT_BITS    = 8;
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS = 32;
  localparam int unsigned LATENCY     = 9;

  localparam logic [GAIN_BITS-1:0] GAIN_ONE = 24'h01_0000;
  localparam logic [GAIN_BITS-1:0] GAIN_MAX = 24'hFF_FFFF;
  localparam logic [U_BITS-1:0]    U_MAX    = 16'hFFFF;
  localparam logic [OUT_BITS-1:0]  OUT_MAX  = 8'd255;
  localparam logic [SHIFT_BITS-1:0] SHIFT_RESET = 5'd10;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_RADIUS_SHIFT,
    REG_COEF_FIRST,
    REG_COEF_SECOND,
    REG_COEF_THIRD
  } cfg_reg_e;

  typedef struct packed {
    logic [CENTER_BITS-1:0] center_x;
    logic [CENTER_BITS-1:0] center_y;
    logic [SHIFT_BITS-1:0]  radius_shift;
  } geom_cfg_t;

  typedef struct packed {
    logic signed [COEF_BITS-1:0] coef_first;
    logic signed [COEF_BITS-1:0] coef_second;
    logic signed [COEF_BITS-1:0] coef_third;
  } coef_cfg_t;

endpackage

### rtl/rvc_radius.sv
// radius stages: centre offset, squares, shifted and saturated radius term
// depends on rvc_pkg
module rvc_radius import rvc_pkg::*; #(
  parameter int unsigned COORD_BITS = 13,
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic [COORD_BITS-1:0]          pos_x_i,
  input  logic [COORD_BITS-1:0]          pos_y_i,
  input  logic [2:0][PIXEL_BITS-1:0]     pix_i,
  input  geom_cfg_t                      cfg_i,
  output logic                           valid_o,
  output logic [U_BITS-1:0]              u_o,
  output logic [2:0][PIXEL_BITS-1:0]     pix_o
);

  localparam int unsigned DW    = COORD_BITS + 1;
  localparam int unsigned SQ_W  = 2 * COORD_BITS;
  localparam int unsigned SUM_W = SQ_W + 1;

  logic [CENTER_BITS+COORD_BITS-1:0] cx_ext, cy_ext;
  logic [COORD_BITS-1:0]             cx_eff, cy_eff;

  logic                         v1_q, v2_q, v3_q;
  logic signed [DW-1:0]         dx_d, dy_d, dx_q, dy_q;
  logic signed [2*DW-1:0]       sqx_full, sqy_full;
  logic [SQ_W-1:0]              sqx_q, sqy_q;
  logic [SUM_W-1:0]             dsq, dsq_sh;
  logic [U_BITS-1:0]            u_d, u_q;
  logic [2:0][PIXEL_BITS-1:0]   pix1_q, pix2_q, pix3_q;

  // centre masked or widened to the coordinate width
  assign cx_ext = {{COORD_BITS{1'b0}}, cfg_i.center_x};
  assign cy_ext = {{COORD_BITS{1'b0}}, cfg_i.center_y};
  assign cx_eff = cx_ext[COORD_BITS-1:0];
  assign cy_eff = cy_ext[COORD_BITS-1:0];

  assign dx_d = $signed({1'b0, pos_x_i}) - $signed({1'b0, cx_eff});
  assign dy_d = $signed({1'b0, pos_y_i}) - $signed({1'b0, cy_eff});

  assign sqx_full = dx_q * dx_q;
  assign sqy_full = dy_q * dy_q;

  assign dsq    = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign dsq_sh = dsq >> cfg_i.radius_shift;
  assign u_d    = (|dsq_sh[SUM_W-1:U_BITS]) ? U_MAX : dsq_sh[U_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    pix1_q <= pix_i;
    sqx_q  <= sqx_full[SQ_W-1:0];
    sqy_q  <= sqy_full[SQ_W-1:0];
    pix2_q <= pix1_q;
    u_q    <= u_d;
    pix3_q <= pix2_q;
  end

  assign valid_o = v3_q;
  assign u_o     = u_q;
  assign pix_o   = pix3_q;

endmodule

### rtl/rvc_gain.sv
// gain stages: powers of the radius term, coefficient products, sum and clamp
// depends on rvc_pkg
module rvc_gain import rvc_pkg::*; #(
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic [U_BITS-1:0]              u_i,
  input  logic [2:0][PIXEL_BITS-1:0]     pix_i,
  input  coef_cfg_t                      coef_i,
  output logic                           valid_o,
  output logic [GAIN_BITS-1:0]           gain_o,
  output logic [2:0][PIXEL_BITS-1:0]     pix_o
);

  localparam int unsigned PROD_W = COEF_BITS + U_BITS + 1;
  localparam int unsigned ACC_W  = PROD_W + 2;
  localparam int unsigned POLY_W = ACC_W - POLY_SHIFT;
  localparam logic [POLY_W-1:0] POLY_LIMIT = POLY_W'(GAIN_MAX - GAIN_ONE);

  logic                        va_q, vb_q, vc_q, vd_q, ve_q;
  logic [2*U_BITS-1:0]         usq, ucube;
  logic [U_BITS-1:0]           ua_q, u2a_q, u3b_q;
  logic signed [PROD_W-1:0]    p1_d, p2_d, p3_d;
  logic signed [PROD_W-1:0]    p1a_q, p1b_q, p2b_q, p3c_q;
  logic signed [ACC_W-1:0]     accc_q, sum_d, sumd_q;
  logic signed [POLY_W-1:0]    poly;
  logic [GAIN_BITS-1:0]        gain_d, gain_q;
  logic [2:0][PIXEL_BITS-1:0]  pixa_q, pixb_q, pixc_q, pixd_q, pixe_q;

  assign usq   = u_i * u_i;
  assign p1_d  = coef_i.coef_first * $signed({1'b0, u_i});
  assign ucube = u2a_q * ua_q;
  assign p2_d  = coef_i.coef_second * $signed({1'b0, u2a_q});
  assign p3_d  = coef_i.coef_third * $signed({1'b0, u3b_q});
  assign sum_d = accc_q + ACC_W'(p3c_q);

  // floor towards minus infinity, then clamp to one and full scale
  assign poly = POLY_W'(sumd_q >>> POLY_SHIFT);

  always_comb begin
    if (sumd_q < 0) begin
      gain_d = GAIN_ONE;
    end else if (poly > $signed(POLY_LIMIT)) begin
      gain_d = GAIN_MAX;
    end else begin
      gain_d = GAIN_ONE + poly[GAIN_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ua_q   <= u_i;
    u2a_q  <= usq[2*U_BITS-1:U_BITS];
    p1a_q  <= p1_d;
    pixa_q <= pix_i;

    u3b_q  <= ucube[2*U_BITS-1:U_BITS];
    p1b_q  <= p1a_q;
    p2b_q  <= p2_d;
    pixb_q <= pixa_q;

    p3c_q  <= p3_d;
    accc_q <= ACC_W'(p1b_q) + ACC_W'(p2b_q);
    pixc_q <= pixb_q;

    sumd_q <= sum_d;
    pixd_q <= pixc_q;

    gain_q <= gain_d;
    pixe_q <= pixd_q;
  end

  assign valid_o = ve_q;
  assign gain_o  = gain_q;
  assign pix_o   = pixe_q;

endmodule

### rtl/rvc_scale.sv
// output stage: channel times gain, truncated and saturated, into result registers
// depends on rvc_pkg
module rvc_scale import rvc_pkg::*; #(
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic [GAIN_BITS-1:0]           gain_i,
  input  logic [2:0][PIXEL_BITS-1:0]     pix_i,
  output logic                           valid_o,
  output logic [OUT_BITS-1:0]            red_o,
  output logic [OUT_BITS-1:0]            green_o,
  output logic [OUT_BITS-1:0]            blue_o,
  output logic [GAIN_BITS-1:0]           gain_o
);

  localparam int unsigned PROD_W = PIXEL_BITS + GAIN_BITS;
  localparam int unsigned SC_W   = PROD_W - 16;

  logic [2:0][PROD_W-1:0]   prod;
  logic [2:0][SC_W-1:0]     scaled;
  logic [2:0][OUT_BITS-1:0] chan_d, chan_q;
  logic                     valid_q;
  logic [GAIN_BITS-1:0]     gain_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i]   = PROD_W'(pix_i[i]) * PROD_W'(gain_i);
      scaled[i] = prod[i][PROD_W-1:16];
      chan_d[i] = (|scaled[i][SC_W-1:OUT_BITS]) ? OUT_MAX : scaled[i][OUT_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    chan_q <= chan_d;
    gain_q <= gain_i;
  end

  assign valid_o = valid_q;
  assign red_o   = chan_q[2];
  assign green_o = chan_q[1];
  assign blue_o  = chan_q[0];
  assign gain_o  = gain_q;

endmodule

### rtl/radial_vignette_correction.sv
// top level of the radial vignette correction pipeline and its register file
// depends on rvc_pkg, rvc_radius, rvc_gain, rvc_scale
//
// One pixel is taken on every clock at which start is high; busy is never raised,
// so the block sustains one pixel per cycle. Each pixel comes out after the full depth
// of the pipeline with result_valid_o high for one cycle; the pipeline has three
// radius stages, five gain stages of registered multiplies, sums and clamp for
// the gain polynomial, and one output stage. The receiver cannot stall the
// results, and none are buffered. Registers are written over the cfg channel,
// which is always ready; write them only while no pixel is in flight, since the
// stages read the registers directly.
module radial_vignette_correction import rvc_pkg::*; #(
  parameter int unsigned COORD_BITS = 13,
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [COORD_BITS-1:0]     pos_x_i,
  input  logic [COORD_BITS-1:0]     pos_y_i,
  input  logic [PIXEL_BITS-1:0]     red_in_i,
  input  logic [PIXEL_BITS-1:0]     green_in_i,
  input  logic [PIXEL_BITS-1:0]     blue_in_i,
  output logic                      result_valid_o,
  output logic [OUT_BITS-1:0]       red_out_o,
  output logic [OUT_BITS-1:0]       green_out_o,
  output logic [OUT_BITS-1:0]       blue_out_o,
  output logic [GAIN_BITS-1:0]      gain_used_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data_i
);

  geom_cfg_t geom_q;
  coef_cfg_t coef_q;

  logic                       accept;
  logic [2:0][PIXEL_BITS-1:0] pix_in, pix_r, pix_g;
  logic                       valid_r, valid_g;
  logic [U_BITS-1:0]          u_r;
  logic [GAIN_BITS-1:0]       gain_g;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;
  assign pix_in      = {red_in_i, green_in_i, blue_in_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geom_q.center_x     <= '0;
      geom_q.center_y     <= '0;
      geom_q.radius_shift <= SHIFT_RESET;
      coef_q.coef_first   <= '0;
      coef_q.coef_second  <= '0;
      coef_q.coef_third   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_CENTER_X:     geom_q.center_x     <= cfg_data_i[CENTER_BITS-1:0];
        REG_CENTER_Y:     geom_q.center_y     <= cfg_data_i[CENTER_BITS-1:0];
        REG_RADIUS_SHIFT: geom_q.radius_shift <= cfg_data_i[SHIFT_BITS-1:0];
        REG_COEF_FIRST:   coef_q.coef_first   <= $signed(cfg_data_i[COEF_BITS-1:0]);
        REG_COEF_SECOND:  coef_q.coef_second  <= $signed(cfg_data_i[COEF_BITS-1:0]);
        REG_COEF_THIRD:   coef_q.coef_third   <= $signed(cfg_data_i[COEF_BITS-1:0]);
        default: begin
        end
      endcase
    end
  end

  rvc_radius #(
    .COORD_BITS (COORD_BITS),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_radius (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .pos_x_i (pos_x_i),
    .pos_y_i (pos_y_i),
    .pix_i   (pix_in),
    .cfg_i   (geom_q),
    .valid_o (valid_r),
    .u_o     (u_r),
    .pix_o   (pix_r)
  );

  rvc_gain #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_gain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_r),
    .u_i     (u_r),
    .pix_i   (pix_r),
    .coef_i  (coef_q),
    .valid_o (valid_g),
    .gain_o  (gain_g),
    .pix_o   (pix_g)
  );

  rvc_scale #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_g),
    .gain_i  (gain_g),
    .pix_i   (pix_g),
    .valid_o (result_valid_o),
    .red_o   (red_out_o),
    .green_o (green_out_o),
    .blue_o  (blue_out_o),
    .gain_o  (gain_used_o)
  );

endmodule

### rtl/rvc_checker.sv
// port-level checker for radial_vignette_correction, attached by bind
// depends on rvc_pkg and radial_vignette_correction_assert.svh
`include "radial_vignette_correction_assert.svh"

module rvc_checker import rvc_pkg::*; #(
  parameter int unsigned PIXEL_BITS = 8
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start,
  input logic                      busy,
  input logic [PIXEL_BITS-1:0]     red_in_i,
  input logic                      result_valid_o,
  input logic [OUT_BITS-1:0]       red_out_o,
  input logic [GAIN_BITS-1:0]      gain_used_o
);

  localparam int unsigned CNT_W = $clog2(LATENCY + 1);

  logic [CNT_W-1:0] warm_q;
  logic             warm;

  // edges since reset, so history before reset is never looked at
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warm_q <= '0;
    end else if (!warm) begin
      warm_q <= warm_q + CNT_W'(1);
    end
  end

  assign warm = (warm_q == CNT_W'(LATENCY));

  `RVC_ASSERT_IMP(a_fixed_latency, warm, result_valid_o == $past(start && !busy, LATENCY), "result strobe does not follow request by the pipeline depth")
  `RVC_ASSERT_IMP(a_gain_floor, result_valid_o, gain_used_o >= GAIN_ONE, "gain below one")
  `RVC_ASSERT_IMP(a_unity_passthrough, warm && result_valid_o && gain_used_o == GAIN_ONE && $past(red_in_i, LATENCY) <= OUT_MAX, red_out_o == $past(red_in_i, LATENCY), "unity gain altered the red sample")

endmodule

bind radial_vignette_correction rvc_checker #(
  .PIXEL_BITS (PIXEL_BITS)
) u_rvc_checker (.*);
